>>> hdl/gll_pkg.sv
`timescale 1ns / 1ps
package gll_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_WIDTH_DEF = 48;

    localparam logic [63:0] LN2_Q64        = 64'hB17217F7D1CF79AC;
    localparam logic [63:0] HALF_LN_2PI_Q60 = 64'd1059463996343540307;

    typedef struct packed {
        logic signed [31:0] observed;
        logic signed [31:0] mean;
        logic signed [31:0] scale;
        logic               last_element;
    } gll_in_t;

    typedef struct packed {
        logic signed [31:0]              grad_mean;
        logic signed [31:0]              grad_scale;
        logic signed [SUM_WIDTH_DEF-1:0] loglik_sum;
        logic                            scale_fault;
        logic                            vector_fault;
        logic                            last_result;
    } gll_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_D,
        ST_SQ_S,
        ST_CUBE,
        ST_DIV_GM,
        ST_DIV_GS,
        ST_DIV_V,
        ST_LOG_MUL,
        ST_LOG_NORM,
        ST_LN_MUL,
        ST_LN_ADD,
        ST_TERM,
        ST_ACC,
        ST_DONE
    } gll_state_t;

endpackage

>>> hdl/gaussian_loglik_gradient.sv
`timescale 1ns / 1ps
// Each element runs in turn through three products (d squared, s squared, s cubed), three
// divisions, 58 log2 squarings, a product and 4 short steps before its result is ready.
// Elements are accepted only when idle; a non-positive scale skips all arithmetic.
// One 32x32 multiplier and one restoring divider are shared by all products and divisions, one element at a time.
// A finished element waits until the output register is free before its result is loaded.
// Asynchronous active-low reset clears the sequencer, the running sum and the fault flag.
module gaussian_loglik_gradient #(
    parameter int FRAC_BITS = gll_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gll_pkg::gll_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gll_pkg::gll_out_t out_data
);

    localparam int SUM_WIDTH = gll_pkg::SUM_WIDTH_DEF;
    localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    gll_pkg::gll_state_t state_reg, state_next;

    logic [31:0]  ad_reg;
    logic         dneg_reg;
    logic [31:0]  us_reg;
    logic         last_reg;
    logic [63:0]  d2_reg, s2_reg;
    logic [127:0] s3_reg;
    logic [31:0]  gm_reg, gs_reg;
    logic [127:0] v_reg;

    // shared divider
    logic [127:0] dn_reg, dd_reg, rem_reg, quo_reg;
    logic [6:0]   cnt_reg;

    // shared multiplier operands and product
    logic [63:0]  ma_reg, mb_reg;
    logic [127:0] prod_reg;
    logic [1:0]   mcnt_reg;

    logic [63:0]  m_reg, lg_reg;
    logic [5:0]   lcnt_reg;
    logic         lneg_reg;

    logic signed [SUM_WIDTH:0]   term_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic                        fault_seen_reg;
    logic                        out_valid_reg;
    gll_pkg::gll_out_t           out_reg;

    // divider step
    logic [127:0] rem_sh, rem_sub, div_q;
    logic         rem_ge;
    always_comb
    begin
        rem_sh  = {rem_reg[126:0], dn_reg[cnt_reg]};
        rem_ge  = rem_sh >= dd_reg;
        rem_sub = rem_sh - dd_reg;
        div_q   = {quo_reg[126:0], rem_ge};
    end

    // A 64x64 product is built from four 32x32 partial products, one per cycle.
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_pp;
    logic [127:0] mul_sum;
    logic         mul_done;
    always_comb
    begin
        mul_a  = mcnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        mul_b  = mcnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        mul_pp = 64'(mul_a) * 64'(mul_b);
        unique case (mcnt_reg)
            2'd0:       mul_sum = prod_reg + 128'(mul_pp);
            2'd1, 2'd2: mul_sum = prod_reg + (128'(mul_pp) << 32);
            2'd3:       mul_sum = prod_reg + (128'(mul_pp) << 64);
        endcase
        mul_done = (mcnt_reg == 2'd3);
    end

    // gradient saturation and sign
    function automatic logic [31:0] sat_grad(input logic [127:0] mag, input logic neg);
        logic [31:0] lim;
        logic [31:0] q;
        begin
            lim = neg ? 32'h80000000 : 32'h7FFFFFFF;
            q = (mag[127:32] != '0 || mag[31:0] > lim) ? lim : mag[31:0];
            sat_grad = neg ? (32'd0 - q) : q;
        end
    endfunction

    logic [5:0] msb_pos;
    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (in_data.scale[i])
            begin
                msb_pos = 6'(i);
            end
        end
    end

    logic signed [32:0] d_w;
    logic [31:0]        ad_w;
    always_comb
    begin
        d_w  = 33'(in_data.observed) - 33'(in_data.mean);
        ad_w = d_w[32] ? 32'(-d_w) : d_w[31:0];
    end

    logic [63:0]        e_val;
    logic               gs_neg;
    logic [63:0]        m_sq, m_next, lg_cur;
    logic signed [64:0] lgs_w;
    always_comb
    begin
        e_val  = (d2_reg >= s2_reg) ? d2_reg - s2_reg : s2_reg - d2_reg;
        gs_neg = d2_reg < s2_reg;
        m_sq   = prod_reg[125:62];
        m_next = m_sq[63] ? (m_sq >> 1) : m_sq;
        lg_cur = lg_reg | (m_sq[63] ? (64'd1 << lcnt_reg) : 64'd0);
        lgs_w  = 65'(lg_cur) - (65'(FRAC_BITS) << 58);
    end

    // term rounding, saturation and accumulation
    logic [127:0] v_abs, q_rnd;
    logic         tpos;
    logic [63:0]  lim_t, mag_t;
    logic signed [SUM_WIDTH:0] term_w, sum_w;
    logic signed [SUM_WIDTH-1:0] sum_new;
    always_comb
    begin
        tpos  = v_reg[127];
        v_abs = tpos ? (128'd0 - v_reg) : v_reg;
        q_rnd = (v_abs + (128'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        lim_t = tpos ? 64'(SMAX) : 64'(SMAX) + 64'd1;
        mag_t = (q_rnd[127:64] != '0 || q_rnd[63:0] > lim_t) ? lim_t : q_rnd[63:0];
        term_w = tpos ? (SUM_WIDTH+1)'(mag_t) : -(SUM_WIDTH+1)'(mag_t);
        sum_w  = (SUM_WIDTH+1)'(sum_reg) + term_reg;
        if (sum_w > (SUM_WIDTH+1)'(SMAX))
        begin
            sum_new = SMAX;
        end
        else if (sum_w < $signed((SUM_WIDTH+1)'(SMIN)))
        begin
            sum_new = SMIN;
        end
        else
        begin
            sum_new = sum_w[SUM_WIDTH-1:0];
        end
    end

    logic start;
    logic div_done;
    assign start    = in_valid && in_ready;
    assign div_done = (cnt_reg == 7'd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gll_pkg::ST_IDLE:     if (start) state_next = in_data.scale > 0 ?
                                      gll_pkg::ST_SQ_D : gll_pkg::ST_DONE;
            gll_pkg::ST_SQ_D:     if (mul_done) state_next = gll_pkg::ST_SQ_S;
            gll_pkg::ST_SQ_S:     if (mul_done) state_next = gll_pkg::ST_CUBE;
            gll_pkg::ST_CUBE:     if (mul_done) state_next = gll_pkg::ST_DIV_GM;
            gll_pkg::ST_DIV_GM:   if (div_done) state_next = gll_pkg::ST_DIV_GS;
            gll_pkg::ST_DIV_GS:   if (div_done) state_next = gll_pkg::ST_DIV_V;
            gll_pkg::ST_DIV_V:    if (div_done) state_next = gll_pkg::ST_LOG_MUL;
            gll_pkg::ST_LOG_MUL:  if (mul_done) state_next = gll_pkg::ST_LOG_NORM;
            gll_pkg::ST_LOG_NORM: state_next = (lcnt_reg == 6'd0) ?
                                      gll_pkg::ST_LN_MUL : gll_pkg::ST_LOG_MUL;
            gll_pkg::ST_LN_MUL:   if (mul_done) state_next = gll_pkg::ST_LN_ADD;
            gll_pkg::ST_LN_ADD:   state_next = gll_pkg::ST_TERM;
            gll_pkg::ST_TERM:     state_next = gll_pkg::ST_ACC;
            gll_pkg::ST_ACC:      state_next = gll_pkg::ST_DONE;
            gll_pkg::ST_DONE:     if (!out_valid_reg) state_next = gll_pkg::ST_IDLE;
            default:              state_next = gll_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == gll_pkg::ST_IDLE);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gll_pkg::ST_IDLE;
            sum_reg        <= '0;
            fault_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == gll_pkg::ST_IDLE && start && !(in_data.scale > 0))
            begin
                fault_seen_reg <= 1'b1;
            end
            if (state_reg == gll_pkg::ST_ACC)
            begin
                sum_reg <= sum_new;
            end
            if (state_reg == gll_pkg::ST_DONE && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    sum_reg        <= '0;
                    fault_seen_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gll_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    dneg_reg <= d_w[32];
                    ad_reg   <= ad_w;
                    us_reg   <= in_data.scale;
                    last_reg <= in_data.last_element;
                    gm_reg   <= '0;
                    gs_reg   <= '0;
                    m_reg    <= 64'(in_data.scale) << (6'd62 - msb_pos);
                    lg_reg   <= 64'(msb_pos) << 58;
                    lcnt_reg <= 6'd57;
                    ma_reg   <= 64'(ad_w);
                    mb_reg   <= 64'(ad_w);
                    prod_reg <= '0;
                    mcnt_reg <= 2'd0;
                end
            end
            gll_pkg::ST_SQ_D, gll_pkg::ST_SQ_S, gll_pkg::ST_CUBE,
            gll_pkg::ST_LOG_MUL, gll_pkg::ST_LN_MUL:
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (!mul_done)
                begin
                    prod_reg <= mul_sum;
                end
                else
                begin
                    unique case (state_reg)
                        gll_pkg::ST_SQ_D:
                        begin
                            d2_reg   <= mul_sum[63:0];
                            prod_reg <= '0;
                            ma_reg   <= 64'(us_reg);
                            mb_reg   <= 64'(us_reg);
                        end
                        gll_pkg::ST_SQ_S:
                        begin
                            s2_reg   <= mul_sum[63:0];
                            prod_reg <= '0;
                            ma_reg   <= mul_sum[63:0];
                            mb_reg   <= 64'(us_reg);
                        end
                        gll_pkg::ST_CUBE:
                        begin
                            s3_reg  <= mul_sum;
                            dn_reg  <= (128'(ad_reg) << (2 * FRAC_BITS + 1)) + 128'(s2_reg);
                            dd_reg  <= 128'(s2_reg) << 1;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= 7'd127;
                        end
                        default:
                        begin
                            prod_reg <= mul_sum;
                        end
                    endcase
                end
            end
            gll_pkg::ST_DIV_GM, gll_pkg::ST_DIV_GS, gll_pkg::ST_DIV_V:
            begin
                if (!div_done)
                begin
                    rem_reg <= rem_ge ? rem_sub : rem_sh;
                    quo_reg <= div_q;
                    cnt_reg <= cnt_reg - 7'd1;
                end
                else
                begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= 7'd127;
                    unique case (state_reg)
                        gll_pkg::ST_DIV_GM:
                        begin
                            gm_reg <= sat_grad(div_q, dneg_reg);
                            dn_reg <= (128'(e_val) << (2 * FRAC_BITS + 1)) + s3_reg;
                            dd_reg <= s3_reg << 1;
                        end
                        gll_pkg::ST_DIV_GS:
                        begin
                            gs_reg <= sat_grad(div_q, gs_neg);
                            dn_reg <= 128'(d2_reg) << 59;
                            dd_reg <= 128'(s2_reg);
                        end
                        default:
                        begin
                            v_reg    <= div_q + 128'(gll_pkg::HALF_LN_2PI_Q60);
                            ma_reg   <= m_reg;
                            mb_reg   <= m_reg;
                            prod_reg <= '0;
                        end
                    endcase
                end
            end
            gll_pkg::ST_LOG_NORM:
            begin
                m_reg    <= m_next;
                lg_reg   <= lg_cur;
                lcnt_reg <= lcnt_reg - 6'd1;
                prod_reg <= '0;
                if (lcnt_reg == 6'd0)
                begin
                    lneg_reg <= lgs_w[64];
                    ma_reg   <= lgs_w[64] ? 64'(-lgs_w) : lgs_w[63:0];
                    mb_reg   <= gll_pkg::LN2_Q64;
                end
                else
                begin
                    ma_reg <= m_next;
                    mb_reg <= m_next;
                end
            end
            gll_pkg::ST_LN_ADD:
            begin
                v_reg <= lneg_reg ? v_reg - (prod_reg >> 62) : v_reg + (prod_reg >> 62);
            end
            gll_pkg::ST_TERM:
            begin
                term_reg <= term_w;
            end
            gll_pkg::ST_ACC:
            begin
            end
            gll_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_reg.grad_mean    <= gm_reg;
                    out_reg.grad_scale   <= gs_reg;
                    out_reg.loglik_sum   <= sum_reg;
                    out_reg.scale_fault  <= !($signed(us_reg) > 0);
                    out_reg.vector_fault <= fault_seen_reg;
                    out_reg.last_result  <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gll_pkg::ST_IDLE) |-> !in_ready)
        else $error("input ready while an element is in progress");

    a_fault_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.scale_fault) |->
            (out_data.grad_mean == 32'd0 && out_data.grad_scale == 32'd0))
        else $error("faulted element produced a non-zero gradient");

    a_fault_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.scale_fault) |-> out_data.vector_fault)
        else $error("element fault not reflected in vector fault");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gll_pkg::ST_DONE && !out_valid_reg && last_reg) |=>
            (sum_reg == '0 && !fault_seen_reg))
        else $error("running state not cleared after the last element");

endmodule

>>> verif/tb_gaussian_loglik_gradient.sv
`timescale 1ns / 1ps
module tb_gaussian_loglik_gradient;

    localparam longint SUM_MAX     = (64'sd1 <<< 47) - 1;
    localparam longint SUM_MIN     = -SUM_MAX - 1;
    localparam int     CYCLE_LIMIT = 5_000_000;
    localparam int     HOLD_CYCLES = 3000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    gll_pkg::gll_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    gll_pkg::gll_out_t out_data;

    gll_pkg::gll_out_t expected_results[$];
    longint   loglik_total;
    bit       vector_faulted;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       error_count;
    int       cycle_count;
    logic     hold_req;
    int       hold_left;

    gaussian_loglik_gradient i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] saturate_gradient(logic [127:0] q, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // log2 of a positive integer, 58 fraction bits, by repeated squaring.
    function automatic logic [63:0] log2_frac58(logic [63:0] s);
        int           k;
        logic [63:0]  m;
        logic [63:0]  lg;
        logic [127:0] p;
        k = 0;
        while (k < 63 && (s >> (k + 1)) != 0)
            k++;
        m  = s << (62 - k);
        lg = 64'(k) << 58;
        for (int i = 57; i >= 0; i--)
        begin
            p = {64'b0, m} * {64'b0, m};
            m = p[125:62];
            if (m[63])
            begin
                m     = m >> 1;
                lg[i] = 1'b1;
            end
        end
        return lg;
    endfunction

    function automatic gll_pkg::gll_out_t predict_element(gll_pkg::gll_in_t x);
        gll_pkg::gll_out_t r;
        longint       d;
        logic [127:0] ad, us, d2, s2, s3, e, num, den, v, q, ln;
        logic [63:0]  lg, mag;
        longint       lgs, term;
        bit           tpos;
        r = '0;
        if (x.scale > 0)
        begin
            d   = longint'(x.observed) - longint'(x.mean);
            ad  = d < 0 ? 128'(-d) : 128'(d);
            us  = 128'(longint'(x.scale));
            d2  = ad * ad;
            s2  = us * us;
            s3  = s2 * us;
            e   = d2 >= s2 ? d2 - s2 : s2 - d2;

            num = (ad << 33) + s2;
            den = s2 << 1;
            r.grad_mean = saturate_gradient(num / den, d < 0);
            num = (e << 33) + s3;
            den = s3 << 1;
            r.grad_scale = saturate_gradient(num / den, d2 < s2);

            // Negated term in units of 2^-60, two's complement over 128 bits.
            v   = ((d2 << 59) / s2) + 128'(gll_pkg::HALF_LN_2PI_Q60);
            lg  = log2_frac58(us[63:0]);
            lgs = longint'(lg) - (longint'(gll_pkg::FRAC_BITS_DEF) <<< 58);
            mag = lgs < 0 ? 64'(-lgs) : 64'(lgs);
            ln  = ({64'b0, mag} * {64'b0, gll_pkg::LN2_Q64}) >> 62;
            v   = lgs < 0 ? v - ln : v + ln;
            tpos = v[127];
            if (tpos)
                v = -v;
            q   = (v + (128'd1 << 43)) >> 44;
            mag = tpos ? 64'(SUM_MAX) : 64'(SUM_MAX) + 1;
            if (q <= 128'(mag))
                mag = q[63:0];
            term = tpos ? longint'(mag) : -longint'(mag);

            if (term > 0 && loglik_total > SUM_MAX - term)
                loglik_total = SUM_MAX;
            else if (term < 0 && loglik_total < SUM_MIN - term)
                loglik_total = SUM_MIN;
            else
                loglik_total += term;
        end
        else
        begin
            r.scale_fault  = 1'b1;
            vector_faulted = 1'b1;
        end
        r.loglik_sum   = loglik_total[47:0];
        r.vector_fault = vector_faulted;
        r.last_result  = x.last_element;
        if (x.last_element)
        begin
            loglik_total   = 0;
            vector_faulted = 1'b0;
        end
        return r;
    endfunction

    // Valid stays high between back-to-back items; it only drops when a gap is taken.
    task automatic send_element(gll_pkg::gll_in_t x);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.insert(expected_results.size(), predict_element(x));
    endtask

    function automatic gll_pkg::gll_in_t make_element(int o, int m, int s, bit last);
        gll_pkg::gll_in_t x;
        x.observed     = o;
        x.mean         = m;
        x.scale        = s;
        x.last_element = last;
        return x;
    endfunction

    task automatic test_extremes();
        send_element(make_element(32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0));
        send_element(make_element(32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0));
        send_element(make_element(32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1));
        send_element(make_element(0, 0, 32'h7FFF_FFFF, 1'b0));
        send_element(make_element(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1'b1));
        send_element(make_element(32'h0001_0000, 0, 32'h0001_0000, 1'b0));
        send_element(make_element(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
        send_element(make_element(-32'sh0002_0000, 0, 32'h0001_0000, 1'b1));
        send_element(make_element(5, 3, 1, 1'b1));
        send_element(make_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    endtask

    // Non-positive scales, both mid-vector and on the closing element.
    task automatic test_faults();
        send_element(make_element(32'h0003_0000, 0, 32'h0001_0000, 1'b0));
        send_element(make_element(32'h0003_0000, 0, 0, 1'b0));
        send_element(make_element(32'h0001_0000, 0, 32'h0002_0000, 1'b1));
        send_element(make_element(0, 0, -1, 1'b0));
        send_element(make_element(0, 0, 32'h8000_0000, 1'b1));
        send_element(make_element(32'h0001_0000, 0, 32'h0001_0000, 1'b1));
        send_element(make_element(0, 0, 0, 1'b1));
    endtask

    function automatic gll_pkg::gll_in_t random_element(bit last);
        gll_pkg::gll_in_t x;
        int      s;
        int      spread;
        x = make_element($urandom, $urandom, $urandom, last);
        if ($urandom_range(99) < 85)
        begin
            // Plausible element: positive scale of any magnitude, observation offset from the mean by a random spread.
            s = int'($urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(30, 0));
            if (s == 0)
                s = 1;
            x.scale    = s;
            spread     = $urandom_range(31, 0);
            x.mean     = int'($urandom) >>> $urandom_range(31, 0);
            x.observed = x.mean + (int'($urandom) >>> spread);
        end
        else if ($urandom_range(99) < 30)
            x.scale = -int'($urandom_range(32'h7FFF_FFFF, 0));
        return x;
    endfunction

    task automatic test_random_vectors(int count);
        int left;
        int len;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len && left > 0; i++)
            begin
                send_element(random_element(i == len - 1 || left == 1));
                left--;
            end
        end
    endtask

    // The receiver holds off while elements keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_element(random_element(i == 5));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    gll_pkg::gll_out_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (out_data.grad_mean !== exp_r.grad_mean)
                    begin
                        $error("grad_mean: expected %0d, got %0d",
                               exp_r.grad_mean, out_data.grad_mean);
                        error_count++;
                    end
                    if (out_data.grad_scale !== exp_r.grad_scale)
                    begin
                        $error("grad_scale: expected %0d, got %0d",
                               exp_r.grad_scale, out_data.grad_scale);
                        error_count++;
                    end
                    if (out_data.loglik_sum !== exp_r.loglik_sum)
                    begin
                        $error("loglik_sum: expected %0d, got %0d",
                               exp_r.loglik_sum, out_data.loglik_sum);
                        error_count++;
                    end
                    if (out_data.scale_fault !== exp_r.scale_fault)
                    begin
                        $error("scale_fault: expected %0b, got %0b",
                               exp_r.scale_fault, out_data.scale_fault);
                        error_count++;
                    end
                    if (out_data.vector_fault !== exp_r.vector_fault)
                    begin
                        $error("vector_fault: expected %0b, got %0b",
                               exp_r.vector_fault, out_data.vector_fault);
                        error_count++;
                    end
                    if (out_data.last_result !== exp_r.last_result)
                    begin
                        $error("last_result: expected %0b, got %0b",
                               exp_r.last_result, out_data.last_result);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        hold_req       = 1'b0;
        loglik_total   = 0;
        vector_faulted = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_faults();
        send_idle_pct  = 50;
        test_random_vectors(340);
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        test_random_vectors(340);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        test_random_vectors(340);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random_vectors(340);
        in_valid <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (600) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
